// ===== rtl/core/tfm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfm_pkg
// Types and constants shared by the temperature fault monitor.
// ----------------------------------------------------------------------------
package tfm_pkg;

    localparam int TEMP_W     = 16;
    localparam int PSTAT_W    = 8;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // Fan turns off at 2 degrees (32 LSB of Q12.4) below the on level.
    localparam logic [TEMP_W:0] FAN_HYST_LSB = (TEMP_W + 1)'(32);

    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTROL_ENABLE = 3'd0,
        CFG_BOARD_MAX      = 3'd1,
        CFG_BOARD_MIN      = 3'd2,
        CFG_PROBE_MAX      = 3'd3,
        CFG_PROBE_MIN      = 3'd4,
        CFG_FAN_ON_LEVEL   = 3'd5
    } cfg_idx_t;

    typedef enum logic [CODE_W-1:0] {
        ST_OK         = 3'd0,
        ST_BOARD_FAIL = 3'd1,
        ST_PROBE_FLT  = 3'd2,
        ST_BOARD_HIGH = 3'd3,
        ST_BOARD_LOW  = 3'd4,
        ST_PROBE_HIGH = 3'd5,
        ST_PROBE_LOW  = 3'd6,
        ST_PROBE_ZERO = 3'd7
    } status_t;

    localparam temp_t BOARD_MAX_RST    = 16'sd1120;
    localparam temp_t BOARD_MIN_RST    = 16'sd0;
    localparam temp_t PROBE_MAX_RST    = 16'sd960;
    localparam temp_t PROBE_MIN_RST    = 16'sd0;
    localparam temp_t FAN_ON_LEVEL_RST = 16'sd480;

endpackage

// ===== rtl/core/temp_fault_monitor_fan_hysteresis.sv =====
// ----------------------------------------------------------------------------
// temp_fault_monitor_fan_hysteresis
// Per-tick temperature fault checks with LED indication and fan hysteresis.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while m_tready does not stall the result
// register; the input register feeds the fault checks and state update,
// which feed the result register combinationally.
// Reset (aresetn low, synchronous): configuration registers return to their defaults,
// tick parity, fan and LED state clear, and both stages empty.
module temp_fault_monitor_fan_hysteresis (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_wr_en,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: board_temp[15:0], probe_temp[31:16], probe_status[39:32]
    input  logic [tfm_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: board_sensor_fail[0]
    input  logic                             s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: status_code[2:0], fan_drive[3], red_led[4], zero[7:5]
    output logic [tfm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tfm_pkg::*;

    // Configuration
    logic  ctrl_en_reg;
    temp_t board_max_reg, board_min_reg, probe_max_reg, probe_min_reg, fan_on_reg;

    // Input stage
    logic              in_valid_reg;
    temp_t             board_reg;
    temp_t             probe_reg;
    logic [PSTAT_W-1:0] pstat_reg;
    logic              bfail_reg;

    // Tick state
    logic parity_reg, fan_state_reg, led_state_reg;
    logic parity_next, fan_state_next, led_state_next;
    status_t code_next;

    // Result stage
    logic             out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic advance;
    logic step;
    logic board_hi, board_lo, probe_hi, probe_lo, probe_zero;
    logic fan_hit_on, fan_hit_off;
    logic signed [TEMP_W:0] probe_ext, fan_on_ext;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_en_reg   <= 1'b0;
            board_max_reg <= BOARD_MAX_RST;
            board_min_reg <= BOARD_MIN_RST;
            probe_max_reg <= PROBE_MAX_RST;
            probe_min_reg <= PROBE_MIN_RST;
            fan_on_reg    <= FAN_ON_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CONTROL_ENABLE: ctrl_en_reg   <= cfg_wdata[0];
                CFG_BOARD_MAX:      board_max_reg <= cfg_wdata;
                CFG_BOARD_MIN:      board_min_reg <= cfg_wdata;
                CFG_PROBE_MAX:      probe_max_reg <= cfg_wdata;
                CFG_PROBE_MIN:      probe_min_reg <= cfg_wdata;
                CFG_FAN_ON_LEVEL:   fan_on_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            board_reg <= s_tdata[15:0];
            probe_reg <= s_tdata[31:16];
            pstat_reg <= s_tdata[39:32];
            bfail_reg <= s_tuser;
        end
    end

    assign board_hi   = board_reg > board_max_reg;
    assign board_lo   = board_reg < board_min_reg;
    assign probe_hi   = probe_reg > probe_max_reg;
    assign probe_lo   = probe_reg < probe_min_reg;
    assign probe_zero = probe_reg == '0;

    // Off threshold compared as probe + 32 <= level, kept in 17 bits.
    assign probe_ext   = {probe_reg[TEMP_W-1], probe_reg};
    assign fan_on_ext  = {fan_on_reg[TEMP_W-1], fan_on_reg};
    assign fan_hit_on  = probe_reg >= fan_on_reg;
    assign fan_hit_off = (probe_ext + signed'(FAN_HYST_LSB)) <= fan_on_ext;

    always_comb begin
        parity_next    = ~parity_reg;
        led_state_next = led_state_reg;
        code_next      = ST_OK;
        if (bfail_reg) begin
            code_next = ST_BOARD_FAIL;
        end else if (pstat_reg != '0) begin
            code_next      = ST_PROBE_FLT;
            led_state_next = 1'b1;
        end else if (board_hi || board_lo) begin
            code_next      = board_hi ? ST_BOARD_HIGH : ST_BOARD_LOW;
            led_state_next = 1'b0;
        end else if (ctrl_en_reg && (probe_hi || probe_lo)) begin
            code_next      = probe_hi ? ST_PROBE_HIGH : ST_PROBE_LOW;
            led_state_next = parity_next;
        end else if (ctrl_en_reg && probe_zero) begin
            code_next      = ST_PROBE_ZERO;
            led_state_next = parity_next;
        end else begin
            led_state_next = 1'b0;
        end
    end

    always_comb begin
        fan_state_next = fan_state_reg;
        if (!ctrl_en_reg) begin
            fan_state_next = 1'b1;
        end else if (code_next != ST_OK) begin
            fan_state_next = 1'b0;
        end else if (!parity_next) begin
            // The off test wins when both bands are met.
            if (fan_hit_off) begin
                fan_state_next = 1'b0;
            end else if (fan_hit_on) begin
                fan_state_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg    <= 1'b0;
            fan_state_reg <= 1'b0;
            led_state_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                parity_reg    <= parity_next;
                fan_state_reg <= fan_state_next;
                led_state_reg <= led_state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {3'b000, led_state_next, fan_state_next, code_next};
        end
    end

`ifndef SYNTH
    a_parity_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> parity_reg != $past(parity_reg))
        else $error("tick parity did not toggle on a processed word");

    a_fan_forced: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !ctrl_en_reg) |=> fan_state_reg)
        else $error("fan not forced on with control disabled");

    a_fault_fan_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ctrl_en_reg && code_next != ST_OK) |=> !fan_state_reg)
        else $error("fan left on during a fault with control enabled");

    a_ok_led_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[CODE_W-1:0] == ST_OK) |-> !out_data_reg[4])
        else $error("red LED lit with status ok");
`endif

endmodule

// ===== sim/tfm_status_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfm_status_checker
// Watches the configuration port and both streams of the temperature fault
// monitor, predicts the status word of every accepted input word, and
// compares each result word against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tfm_status_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tfm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tfm_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             outstanding
);
    import tfm_pkg::*;

    typedef struct packed {
        logic    led;
        logic    fan;
        status_t code;
    } verdict_t;

    // Shadow of the register file.
    logic  ctl_en;
    temp_t board_hi;
    temp_t board_lo;
    temp_t probe_hi;
    temp_t probe_lo;
    temp_t fan_level;

    // Shadow of the per-tick state.
    logic tick_odd;
    logic fan_on;
    logic led_on;

    verdict_t status_due[$];
    int       errors;

    function automatic verdict_t judge_tick(temp_t board, logic board_fail, temp_t probe,
                                            logic [PSTAT_W-1:0] pstat);
        verdict_t v;
        v.code   = ST_OK;
        tick_odd = ~tick_odd;
        if (board_fail) begin
            v.code = ST_BOARD_FAIL;
        end else if (pstat != '0) begin
            v.code = ST_PROBE_FLT;
            led_on = 1'b1;
        end else if (board > board_hi || board < board_lo) begin
            v.code = (board > board_hi) ? ST_BOARD_HIGH : ST_BOARD_LOW;
            led_on = 1'b0;
        end else if (ctl_en && (probe > probe_hi || probe < probe_lo)) begin
            v.code = (probe > probe_hi) ? ST_PROBE_HIGH : ST_PROBE_LOW;
            led_on = tick_odd;
        end else if (ctl_en && probe == 0) begin
            v.code = ST_PROBE_ZERO;
            led_on = tick_odd;
        end else begin
            led_on = 1'b0;
        end

        if (!ctl_en) begin
            fan_on = 1'b1;
        end else if (v.code != ST_OK) begin
            fan_on = 1'b0;
        end else if (!tick_odd) begin
            if (probe >= fan_level)
                fan_on = 1'b1;
            // The off point is taken in a wider range so it cannot wrap.
            if (int'(probe) <= int'(fan_level) - int'(FAN_HYST_LSB))
                fan_on = 1'b0;
        end
        v.fan = fan_on;
        v.led = led_on;
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t due;
        if (!aresetn) begin
            ctl_en    = 1'b0;
            board_hi  = BOARD_MAX_RST;
            board_lo  = BOARD_MIN_RST;
            probe_hi  = PROBE_MAX_RST;
            probe_lo  = PROBE_MIN_RST;
            fan_level = FAN_ON_LEVEL_RST;
            tick_odd  = 1'b0;
            fan_on    = 1'b0;
            led_on    = 1'b0;
            status_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CONTROL_ENABLE: ctl_en    = cfg_wdata[0];
                    CFG_BOARD_MAX:      board_hi  = temp_t'(cfg_wdata);
                    CFG_BOARD_MIN:      board_lo  = temp_t'(cfg_wdata);
                    CFG_PROBE_MAX:      probe_hi  = temp_t'(cfg_wdata);
                    CFG_PROBE_MIN:      probe_lo  = temp_t'(cfg_wdata);
                    CFG_FAN_ON_LEVEL:   fan_level = temp_t'(cfg_wdata);
                    default: ;
                endcase
            end

            // Results leave before new words enter, so a pop never sees a
            // prediction made at the same edge.
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                end else begin
                    due = status_due.pop_front();
                    if (m_tdata != {3'b000, due}) begin
                        errors++;
                        $display("%0t: mismatch expected code=%0d fan=%0b led=%0b pad=0, %s",
                                 $time, due.code, due.fan, due.led, "");
                        $display("%0t:          actual   code=%0d fan=%0b led=%0b pad=%0d",
                                 $time, m_tdata[2:0], m_tdata[3], m_tdata[4], m_tdata[7:5]);
                    end
                end
            end

            if (s_tvalid && s_tready)
                status_due.push_back(judge_tick(temp_t'(s_tdata[15:0]), s_tuser,
                                                temp_t'(s_tdata[31:16]), s_tdata[39:32]));
        end
        outstanding <= status_due.size();
    end

    initial errors = 0;
    assign fail_count = errors;

endmodule

// ===== sim/temp_fault_monitor_fan_hysteresis_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temp_fault_monitor_fan_hysteresis_tb
// Drives directed and randomized sensor words through the fault monitor
// under several register settings, with random idle cycles on both streams,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module temp_fault_monitor_fan_hysteresis_tb;
    import tfm_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int WORDS_PER_PHASE = 250;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int failures;
    int outstanding;
    int cycles = 0;

    // Flow control: steady_flow is shared by the sender and the receiver; hold_request is for the receiver only.
    bit steady_flow = 1'b0;
    bit hold_request = 1'b0;

    // Current settings, kept only to aim the random words.
    int cur_bmax, cur_bmin, cur_pmax, cur_pmin, cur_level;

    always #6 aclk = ~aclk;

    temp_fault_monitor_fan_hysteresis u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tfm_status_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (failures),
        .outstanding (outstanding)
    );

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int pick_in(int lo, int hi);
        int t;
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        return clamp16(lo) + int'($urandom_range(0, clamp16(hi) - clamp16(lo)));
    endfunction

    function automatic int any16();
        return int'($signed(16'($urandom)));
    endfunction

    task automatic send_word(int board, bit board_fail, int probe, int pstat);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pstat[7:0], probe[15:0], board[15:0]};
        s_tuser  <= board_fail;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering words and waits until every prediction has been matched.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        @(posedge aclk);
    endtask

    task automatic set_config(int en, int bmax, int bmin, int pmax, int pmin, int level);
        wait_idle();
        cur_bmax  = bmax;
        cur_bmin  = bmin;
        cur_pmax  = pmax;
        cur_pmin  = pmin;
        cur_level = level;
        // Upper bits of the enable word are noise; only bit 0 counts.
        write_reg(CFG_CONTROL_ENABLE, int'($urandom & 32'hFFFE) | (en & 1));
        write_reg(CFG_BOARD_MAX, bmax);
        write_reg(CFG_BOARD_MIN, bmin);
        write_reg(CFG_PROBE_MAX, pmax);
        write_reg(CFG_PROBE_MIN, pmin);
        write_reg(CFG_FAN_ON_LEVEL, level);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random stalls per word, none in steady phases, and one long
    // hold-off on request so the pipeline fills and back-pressures.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                stall = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = steady_flow ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int p, k, r;
        int en, bmax, bmin, pmax, pmin, level;
        int board, probe, pstat;
        bit board_fail;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: control disabled, so the fan is forced on and a zero
        // probe reading is not a fault.
        send_word(500, 0, 500, 0);
        send_word(500, 1, 500, 0);
        send_word(500, 0, 0, 0);

        set_config(1, 1120, 0, 960, 0, 480);
        send_word(2000, 1, 0, 8'h55);       // sensor failure outranks everything
        send_word(500, 0, 500, 8'h01);
        send_word(500, 0, 500, 8'h80);
        send_word(-32768, 0, 500, 8'hFF);   // converter fault outranks board limits
        send_word(1121, 0, 500, 0);
        send_word(1120, 0, 500, 0);
        send_word(-1, 0, 500, 0);
        send_word(32767, 0, 500, 0);
        send_word(-32768, 0, 500, 0);
        send_word(500, 0, 961, 0);
        send_word(500, 0, -1, 0);
        send_word(500, 0, 0, 0);
        send_word(500, 0, 32767, 0);
        send_word(500, 0, -32768, 0);
        // Walk the hysteresis band on both tick parities.
        send_word(500, 0, 480, 0);
        send_word(500, 0, 480, 0);
        send_word(500, 0, 460, 0);
        send_word(500, 0, 460, 0);
        send_word(500, 0, 448, 0);
        send_word(500, 0, 448, 0);
        send_word(500, 0, 449, 0);
        send_word(500, 0, 449, 0);
        send_word(500, 1, 449, 0);          // LED holds through a sensor failure

        // Crossed limits: both violated at once, the high code wins.
        set_config(1, 1120, 0, -100, 100, 480);
        send_word(500, 0, 0, 0);
        set_config(1, -100, 100, 960, 0, 480);
        send_word(0, 0, 500, 0);

        for (p = 0; p < 8; p++) begin
            en   = (p == 3 || p == 7) ? 0 : 1;
            bmin = pick_in(-800, 400);
            bmax = bmin + int'($urandom_range(0, 1600));
            pmin = pick_in(-800, 400);
            pmax = pmin + int'($urandom_range(200, 1600));
            level = pick_in(pmin, pmax);
            case (p)
                2: begin
                    bmin  = -32768;
                    bmax  = 32767;
                    pmin  = -32768;
                    pmax  = 32767;
                    level = -32768;
                end
                4: begin
                    pmax  = 32767;
                    level = 32767;
                end
                5: begin
                    bmin = 200;
                    bmax = -200;
                end
                6: begin
                    pmin = 300;
                    pmax = -300;
                end
                default: ;
            endcase
            set_config(en, bmax, bmin, pmax, pmin, level);
            steady_flow  = (p == 1);
            hold_request = (p == 4);

            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                board_fail = ($urandom_range(0, 99) < 6);
                pstat = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, 255)) : 0;
                board = ($urandom_range(0, 99) < 85) ? pick_in(cur_bmin, cur_bmax) : any16();
                r = $urandom_range(0, 99);
                if (r < 55)
                    probe = pick_in(cur_level - 40, cur_level + 8);
                else if (r < 65)
                    probe = 0;
                else if (r < 80)
                    probe = pick_in(cur_pmin, cur_pmax);
                else if (r < 90)
                    probe = clamp16(($urandom_range(0, 1) ? cur_pmax : cur_pmin)
                                    + int'($urandom_range(0, 2)) - 1);
                else
                    probe = any16();
                send_word(board, board_fail, probe, pstat);
            end
        end
        steady_flow = 1'b0;

        wait_idle();
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tfm_pkg.sv
rtl/core/temp_fault_monitor_fan_hysteresis.sv
sim/tfm_status_checker.sv
sim/temp_fault_monitor_fan_hysteresis_tb.sv
